@@ sv/clps_pkg.sv @@
// Package for the chained LED panel column shifter.
// Holds the command and status types, the pixel width and the LED frame encoder.
// No dependencies.
`timescale 1ns / 1ps

package clps_pkg;

  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FRAME_W  = 32;
  localparam int PIX_W    = 16;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [MODE_W-1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_SHIFT    = 2'd1,
    OP_SEND     = 2'd2,
    OP_REFRESH  = 2'd3
  } op_t;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STAT_OK      = 2'd0;
  localparam status_t STAT_RX_FULL = 2'd1;
  localparam status_t STAT_TX_DONE = 2'd2;

  typedef struct packed {
    op_t              op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // Driver frame: 111 bbbb 0 bbbb 0000 gggg 0000 rrrr 0000.
  function automatic logic [FRAME_W-1:0] frame_of(input logic [PIX_W-1:0] px);
    frame_of = {3'b111, px[15:12], 1'b0, px[11:8], 4'b0000,
                px[7:4], 4'b0000, px[3:0], 4'b0000};
  endfunction

endpackage

@@ sv/clps_in_if.sv @@
// Input channel of the column shifter: valid, ready, mode and data byte.
// Depends on clps_pkg.
`timescale 1ns / 1ps

interface clps_in_if import clps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data_byte;

  modport source(output valid, mode, data_byte, input ready);
  modport sink(input valid, mode, data_byte, output ready);
endinterface

@@ sv/clps_out_if.sv @@
// Result channel of the column shifter: valid, ready and the result fields.
// Depends on clps_pkg.
`timescale 1ns / 1ps

interface clps_out_if import clps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   out_byte;
  logic [FRAME_W-1:0]  led_frame;
  logic                last_frame;

  modport source(output valid, status, out_byte, led_frame, last_frame, input ready);
  modport sink(input valid, status, out_byte, led_frame, last_frame, output ready);
endinterface

@@ sv/clps_front.sv @@
// Front end: registers each input transfer and decodes its mode into a command.
// Depends on clps_pkg and clps_in_if.
`timescale 1ns / 1ps

module clps_front import clps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  clps_in_if.sink     in_chan,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_ready
);

  logic hold_valid_r;
  cmd_t hold_cmd_r;
  op_t  op_dec;

  always_comb begin
    case (in_chan.mode)
      2'd0:    op_dec = OP_RX_BYTE;
      2'd1:    op_dec = OP_SHIFT;
      2'd2:    op_dec = OP_SEND;
      2'd3:    op_dec = OP_REFRESH;
      default: op_dec = OP_RX_BYTE;
    endcase
  end

  assign in_chan.ready = !hold_valid_r || cmd_ready;
  assign cmd_valid     = hold_valid_r;
  assign cmd           = hold_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      hold_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      hold_cmd_r.op   <= op_dec;
      hold_cmd_r.data <= in_chan.data_byte;
    end
  end

endmodule

@@ sv/clps_queue.sv @@
// Short command queue between the front end and the execution back end.
// Depends on clps_pkg.
`timescale 1ns / 1ps

module clps_queue import clps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  cmd_t           slot_r [QDEPTH];
  logic [QAW-1:0] wptr_r;
  logic [QAW-1:0] rptr_r;
  logic [QAW:0]   cnt_r;
  logic           push;
  logic           pop;

  assign push_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/clps_back.sv @@
// Back end: executes commands against the pixel memory, receive and send buffers.
// Depends on clps_pkg and clps_out_if.
`timescale 1ns / 1ps

module clps_back import clps_pkg::*; #(
  parameter int PANEL_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_ready,
  clps_out_if.source  out_chan
);

  localparam int N     = PANEL_SIZE;
  localparam int CW    = $clog2(N);
  localparam int CW1   = CW + 1;
  localparam int IW    = $clog2(N + 1);
  localparam int RCW   = $clog2(2 * N + 1);
  localparam int AW    = $clog2(N * N);
  localparam int DEPTH = N * N;

  localparam logic [CW-1:0]  LAST_C = CW'(N - 1);
  localparam logic [CW:0]    N_C1   = CW1'(N);
  localparam logic [IW-1:0]  N_I    = IW'(N);
  localparam logic [RCW-1:0] RX_LEN = RCW'(2 * N);
  localparam logic [AW-1:0]  N_A    = AW'(N);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_RESP  = 5'b00100,
    S_RD    = 5'b01000,
    S_LD    = 5'b10000
  } state_t;

  state_t            state_r;
  logic [PIX_W-1:0]  pix_mem [DEPTH];
  logic [PIX_W-1:0]  rd_data_r;
  logic [N-1:0]      col_valid_r;
  logic [CW-1:0]     head_r;
  logic [PIX_W-1:0]  rx_pair_r [N];
  logic [RCW-1:0]    rx_count_r;
  logic [PIX_W-1:0]  send_col_r [N];
  logic [IW-1:0]     send_idx_r;
  logic              send_half_r;
  logic [IW-1:0]     row_r;
  logic [CW-1:0]     fc_r;
  logic [CW-1:0]     fr_r;
  logic              src_valid_r;
  logic              pvalid_r;

  logic                out_valid_r;
  status_t             status_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [FRAME_W-1:0]  frame_r;
  logic                last_r;

  logic              slot_free;
  logic              pop;
  logic              out_load;
  logic              out_valid_nxt;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [PIX_W-1:0]  mem_wdata;
  logic [AW-1:0]     shift_addr;
  logic [IW-1:0]     row_m1;
  logic [CW-1:0]     ref_lc;
  logic [CW:0]       ref_sum;
  logic [CW:0]       ref_diff;
  logic [CW-1:0]     ref_pc;
  logic [CW-1:0]     ref_row;
  logic [AW-1:0]     ref_addr;
  logic              ref_last;
  logic [PIX_W-1:0]  send_word;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign cmd_ready = (state_r == S_IDLE) &&
                     (slot_free || cmd.op == OP_SHIFT || cmd.op == OP_REFRESH);
  assign pop       = cmd_valid && cmd_ready;

  assign out_load      = (pop && (cmd.op == OP_RX_BYTE || cmd.op == OP_SEND)) ||
                         (state_r == S_RESP && slot_free) ||
                         (state_r == S_LD && slot_free);
  assign out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);

  assign shift_addr = AW'(row_r[CW-1:0]) * N_A + AW'(head_r);
  assign row_m1     = row_r - IW'(1);

  assign ref_lc   = LAST_C - fc_r;
  assign ref_sum  = {1'b0, head_r} + {1'b0, ref_lc};
  assign ref_diff = ref_sum - N_C1;
  assign ref_pc   = (ref_sum >= N_C1) ? ref_diff[CW-1:0] : ref_sum[CW-1:0];
  assign ref_row  = ref_lc[0] ? (LAST_C - fr_r) : fr_r;
  assign ref_addr = AW'(ref_row) * N_A + AW'(ref_pc);
  assign ref_last = (fc_r == LAST_C) && (fr_r == LAST_C);

  assign send_word = send_col_r[send_idx_r[CW-1:0]];

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = rx_pair_r[row_r[CW-1:0]];
    case (state_r)
      S_SHIFT: begin
        if (row_r < N_I) begin
          mem_we   = 1'b1;
          mem_re   = 1'b1;
          mem_addr = shift_addr;
        end
      end
      S_RD: begin
        mem_re   = 1'b1;
        mem_addr = ref_addr;
      end
      default: begin
      end
    endcase
  end

  // The read returns the old word when it hits the address being written.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pix_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= pix_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      col_valid_r <= '0;
      head_r      <= '0;
      rx_count_r  <= '0;
      send_idx_r  <= '0;
      send_half_r <= 1'b0;
      row_r       <= '0;
      fc_r        <= '0;
      fr_r        <= '0;
      src_valid_r <= 1'b0;
      pvalid_r    <= 1'b0;
      for (int i = 0; i < N; i++) begin
        rx_pair_r[i]  <= '0;
        send_col_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            case (cmd.op)
              OP_RX_BYTE: begin
                byte_r      <= '0;
                frame_r     <= '0;
                last_r      <= 1'b1;
                if (rx_count_r < RX_LEN) begin
                  if (!rx_count_r[0]) begin
                    rx_pair_r[rx_count_r[CW:1]][15:8] <= cmd.data;
                  end else begin
                    rx_pair_r[rx_count_r[CW:1]][7:0] <= cmd.data;
                  end
                  rx_count_r <= rx_count_r + RCW'(1);
                  status_r   <= STAT_OK;
                end else begin
                  status_r <= STAT_RX_FULL;
                end
              end
              OP_SHIFT: begin
                row_r       <= '0;
                src_valid_r <= col_valid_r[head_r];
                state_r     <= S_SHIFT;
              end
              OP_SEND: begin
                frame_r     <= '0;
                last_r      <= 1'b1;
                if (send_idx_r < N_I) begin
                  status_r <= STAT_OK;
                  if (!send_half_r) begin
                    byte_r      <= send_word[15:8];
                    send_half_r <= 1'b1;
                  end else begin
                    byte_r      <= send_word[7:0];
                    send_half_r <= 1'b0;
                    send_idx_r  <= send_idx_r + IW'(1);
                  end
                end else begin
                  status_r <= STAT_TX_DONE;
                  byte_r   <= '0;
                end
              end
              OP_REFRESH: begin
                fc_r    <= '0;
                fr_r    <= '0;
                state_r <= S_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (row_r != '0) begin
            send_col_r[row_m1[CW-1:0]] <= src_valid_r ? rd_data_r : '0;
          end
          row_r <= row_r + IW'(1);
          if (row_r == N_I) begin
            col_valid_r[head_r] <= 1'b1;
            head_r      <= (head_r == LAST_C) ? '0 : head_r + CW'(1);
            rx_count_r  <= '0;
            send_idx_r  <= '0;
            send_half_r <= 1'b0;
            state_r     <= S_RESP;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            status_r    <= STAT_OK;
            byte_r      <= '0;
            frame_r     <= '0;
            last_r      <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_RD: begin
          pvalid_r <= col_valid_r[ref_pc];
          state_r  <= S_LD;
        end
        S_LD: begin
          if (slot_free) begin
            status_r    <= STAT_OK;
            byte_r      <= '0;
            frame_r     <= frame_of(pvalid_r ? rd_data_r : '0);
            last_r      <= ref_last;
            if (ref_last) begin
              state_r <= S_IDLE;
            end else begin
              if (fr_r == LAST_C) begin
                fr_r <= '0;
                fc_r <= fc_r + CW'(1);
              end else begin
                fr_r <= fr_r + CW'(1);
              end
              state_r <= S_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = status_r;
  assign out_chan.out_byte   = byte_r;
  assign out_chan.led_frame  = frame_r;
  assign out_chan.last_frame = last_r;

endmodule

@@ sv/chained_led_panel_column_shifter_core.sv @@
// Top level of the chained LED panel column shifter.
// Depends on clps_pkg, clps_in_if, clps_out_if, clps_front, clps_queue, clps_back.
//
// Usage: in_chan carries one command per transfer (mode and data byte), out_chan
// returns the results, each with valid and ready. Mode 0 stores a received byte,
// mode 1 decodes the stored bytes into a new column and shifts the panel left,
// mode 2 returns the next byte of the column leaving the panel, and mode 3
// returns one LED frame per pixel in serpentine order, PANEL_SIZE squared frames
// with last_frame set on the final one. Modes 0, 1 and 2 give one result each.
// Commands pass through an input register and a two-entry queue before the back
// end, which loads each mode 0 or 2 result into the output register and takes
// one such command per cycle while out_chan takes each result. Mode 1 holds the
// back end for the single-port walk down the pixel memory column, then offers
// its result; mode 3 makes each frame with one memory read and one output load.
// The front end keeps taking commands into the queue while a result waits; once
// the queue and input register are full, in_chan ready drops until out_chan
// frees the output register. Reset marks every panel column empty, so pixels
// read as zero, clears the buffers and all counters; no clearing pass is needed.
`timescale 1ns / 1ps

module chained_led_panel_column_shifter_core import clps_pkg::*; #(
  parameter int PANEL_SIZE = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  clps_in_if.sink    in_chan,
  clps_out_if.source out_chan
);

  logic f_valid;
  cmd_t f_cmd;
  logic f_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic q_ready;

  clps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  clps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_cmd   (f_cmd),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop_ready  (q_ready)
  );

  clps_back #(
    .PANEL_SIZE (PANEL_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .out_chan  (out_chan)
  );

endmodule

@@ tb/clps_panel_checker.sv @@
// Checker for the chained LED panel column shifter: predicts every result from the
// accepted commands and compares each result transfer field by field.
// Depends on clps_pkg, clps_in_if and clps_out_if.
`timescale 1ns / 1ps

module clps_panel_checker import clps_pkg::*; #(
  parameter int PANEL_SIZE = 8
) (
  input  logic clk,
  input  logic rst_n,
  clps_in_if   in_mon,
  clps_out_if  out_mon,
  output int   fail_count,
  output int   results_due,
  output int   results_checked
);

  typedef struct packed {
    status_t              status;
    logic [BYTE_W-1:0]    out_byte;
    logic [FRAME_W-1:0]   led_frame;
    logic                 last_frame;
  } panel_result_t;

  logic [PIX_W-1:0]  pixels [PANEL_SIZE*PANEL_SIZE];
  logic [BYTE_W-1:0] rx_bytes [2*PANEL_SIZE];
  logic [PIX_W-1:0]  tx_column [PANEL_SIZE];
  int unsigned       rx_fill;
  int unsigned       tx_index;
  bit                tx_low;
  panel_result_t     panel_results_due[$];
  int                mismatches;
  int                checked;

  task automatic apply_panel_command(input op_t op, input logic [BYTE_W-1:0] data);
    panel_result_t    res;
    logic [PIX_W-1:0] fresh [PANEL_SIZE];
    logic [PIX_W-1:0] px;
    int               row;
    int               col;
    res = '0;
    res.status = STAT_OK;
    res.last_frame = 1'b1;
    case (op)
      OP_RX_BYTE: begin
        if (rx_fill < 2*PANEL_SIZE) begin
          rx_bytes[rx_fill] = data;
          rx_fill++;
        end else begin
          res.status = STAT_RX_FULL;
        end
        panel_results_due.push_back(res);
      end
      OP_SHIFT: begin
        for (int r = 0; r < PANEL_SIZE; r++) fresh[r] = {rx_bytes[2*r], rx_bytes[2*r+1]};
        for (int r = 0; r < PANEL_SIZE; r++) begin
          tx_column[r] = pixels[r*PANEL_SIZE];
          for (int c = 0; c < PANEL_SIZE - 1; c++)
            pixels[r*PANEL_SIZE + c] = pixels[r*PANEL_SIZE + c + 1];
          pixels[r*PANEL_SIZE + PANEL_SIZE - 1] = fresh[r];
        end
        rx_fill = 0;
        tx_index = 0;
        tx_low = 1'b0;
        panel_results_due.push_back(res);
      end
      OP_SEND: begin
        if (tx_index >= PANEL_SIZE) begin
          res.status = STAT_TX_DONE;
        end else if (!tx_low) begin
          res.out_byte = tx_column[tx_index][15:8];
          tx_low = 1'b1;
        end else begin
          res.out_byte = tx_column[tx_index][7:0];
          tx_low = 1'b0;
          tx_index++;
        end
        panel_results_due.push_back(res);
      end
      default: begin
        // Columns go out right to left; odd columns run bottom to top.
        for (int c = 0; c < PANEL_SIZE; c++) begin
          col = PANEL_SIZE - 1 - c;
          for (int r = 0; r < PANEL_SIZE; r++) begin
            row = (col % 2 == 0) ? r : PANEL_SIZE - 1 - r;
            px = pixels[row*PANEL_SIZE + col];
            res.led_frame = 32'hE000_0000 | (32'(px[15:12]) << 25) | (32'(px[11:8]) << 20)
                            | (32'(px[7:4]) << 12) | (32'(px[3:0]) << 4);
            res.last_frame = (c == PANEL_SIZE - 1) && (r == PANEL_SIZE - 1);
            panel_results_due.push_back(res);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    panel_result_t got;
    panel_result_t want;
    if (!rst_n) begin
      foreach (pixels[i]) pixels[i] = '0;
      foreach (rx_bytes[i]) rx_bytes[i] = '0;
      foreach (tx_column[i]) tx_column[i] = '0;
      rx_fill = 0;
      tx_index = 0;
      tx_low = 1'b0;
      panel_results_due.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) apply_panel_command(op_t'(in_mon.mode), in_mon.data_byte);
      if (out_mon.valid && out_mon.ready) begin
        got.status = out_mon.status;
        got.out_byte = out_mon.out_byte;
        got.led_frame = out_mon.led_frame;
        got.last_frame = out_mon.last_frame;
        if (panel_results_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unpredicted result: status %0d byte %02h frame %08h last %0d",
                     $realtime, got.status, got.out_byte, got.led_frame, got.last_frame);
          mismatches++;
        end else begin
          want = panel_results_due.pop_front();
          if (got.status !== want.status || got.out_byte !== want.out_byte ||
              got.led_frame !== want.led_frame || got.last_frame !== want.last_frame) begin
            if (mismatches < 10)
              $display("%0t: result %0d mismatch: expected status %0d byte %02h frame %08h last %0d, got status %0d byte %02h frame %08h last %0d",
                       $realtime, checked, want.status, want.out_byte, want.led_frame,
                       want.last_frame, got.status, got.out_byte, got.led_frame,
                       got.last_frame);
            mismatches++;
          end
        end
        checked++;
      end
    end
    fail_count <= mismatches;
    results_checked <= checked;
    results_due <= panel_results_due.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the chained LED panel column shifter: clock, reset, command
// stimulus, result back-pressure, watchdog and verdict.
// Depends on clps_pkg, the channel interfaces, the core and clps_panel_checker.
`timescale 1ns / 1ps

module tb import clps_pkg::*;;

  localparam int PANEL       = 8;
  localparam int CLK_HALF    = 5;
  localparam int ITEM_TARGET = 230;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN       = 20;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   results_due;
  int   results_checked;
  int   items_sent;
  int   mode_counts [4];
  int   quiet_cycles;

  clps_in_if  in_chan();
  clps_out_if out_chan();

  chained_led_panel_column_shifter_core #(.PANEL_SIZE(PANEL)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  clps_panel_checker #(.PANEL_SIZE(PANEL)) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .fail_count      (fail_count),
    .results_due     (results_due),
    .results_checked (results_checked)
  );

  always #CLK_HALF clk = ~clk;

  task automatic offer_command(input op_t op, input logic [BYTE_W-1:0] data);
    int gap;
    gap = (((items_sent / 30) % 4) == 2) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.mode <= op;
    in_chan.data_byte <= data;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
    mode_counts[op]++;
  endtask

  initial begin
    logic [BYTE_W-1:0] patterns [16];
    int n_bytes;
    int n_sends;
    patterns = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hF0, 8'h0F, 8'h80,
                 8'h01, 8'h7F, 8'hFE, 8'hC3, 8'h3C, 8'h12, 8'hED,
                 8'h99, 8'h66};
    in_chan.valid = 1'b0;
    in_chan.mode = OP_RX_BYTE;
    in_chan.data_byte = '0;
    items_sent = 0;
    foreach (mode_counts[i]) mode_counts[i] = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    offer_command(OP_SEND, 8'h00);
    offer_command(OP_REFRESH, 8'hFF);
    foreach (patterns[i]) offer_command(OP_RX_BYTE, patterns[i]);
    offer_command(OP_RX_BYTE, 8'hFF);
    offer_command(OP_SHIFT, 8'h00);
    // A shift with nothing received reuses the bytes of the previous column.
    offer_command(OP_SHIFT, 8'hFF);
    offer_command(OP_REFRESH, 8'h00);
    offer_command(OP_SEND, 8'hFF);
    offer_command(OP_SEND, 8'h00);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       n_bytes = $urandom_range(0, 15);
        1:       n_bytes = $urandom_range(17, 18);
        default: n_bytes = 16;
      endcase
      repeat (n_bytes) offer_command(OP_RX_BYTE, 8'($urandom));
      if ($urandom_range(0, 4) == 0) offer_command(op_t'($urandom_range(0, 3)), 8'($urandom));
      offer_command(OP_SHIFT, 8'($urandom));
      n_sends = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 6);
      repeat (n_sends) offer_command(OP_SEND, 8'($urandom));
      if ($urandom_range(0, 1) == 0) offer_command(OP_REFRESH, 8'($urandom));
    end
    in_chan.valid <= 1'b0;

    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d commands: %0d bytes, %0d shifts, %0d sends, %0d refreshes.",
             items_sent, mode_counts[OP_RX_BYTE], mode_counts[OP_SHIFT],
             mode_counts[OP_SEND], mode_counts[OP_REFRESH]);
    $display("Checked %0d results, %0d failed.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // The receiver stalls at random and, once, holds off long enough to back up the input.
  initial begin
    int stall;
    int taken;
    out_chan.ready = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else if (((taken / 150) % 4) == 3) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles.", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
